>>> rtl/core/qrm_pkg.sv
`default_nettype none
package qrm_pkg;

	localparam int InW    = 16;
	localparam int OutW   = 16;
	localparam int FracW  = 14;
	localparam int Lanes  = 9;
	localparam int ProdW  = 32;
	localparam int NormW  = 33;
	localparam int NumW   = 35;
	localparam int MagW   = 33;
	localparam int QBits  = FracW + 1;
	localparam int RemW   = MagW + QBits + 1;
	localparam int DenW   = NormW + 1;
	localparam int QOutW  = QBits + 2;

	localparam logic signed [QOutW-1:0] EntryMax = QOutW'(32767);
	localparam logic signed [QOutW-1:0] EntryMin = -QOutW'(32768);

	typedef logic signed [InW-1:0]  comp_t;
	typedef logic signed [OutW-1:0] entry_t;

	function automatic entry_t sat_entry(input logic signed [QOutW-1:0] v);
		if (v > EntryMax)
			return entry_t'(EntryMax);
		else if (v < EntryMin)
			return entry_t'(EntryMin);
		else
			return entry_t'(v);
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/quaternion_to_rotation_matrix.sv
// channel | signals                                        | handshake
// in      | quat_x, quat_y, quat_z, quat_w (Q3.12)         | start & !busy
// out     | m_r0c0 .. m_r2c2 (Q1.14), degenerate           | done, one cycle
//
// one item enters per cycle; busy is always low
// the pipeline has 20 register stages: input, products, sums, operand prep,
// 15 restoring divide stages (one quotient bit each), output;
// done is the output stage's valid bit, set as an item leaves the last divide stage
// reset clears only the valid bits; payload registers are not reset
// the receiver cannot stall, so the pipeline never holds
`default_nettype none
module quaternion_to_rotation_matrix (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  qrm_pkg::comp_t      quat_x,
	input  qrm_pkg::comp_t      quat_y,
	input  qrm_pkg::comp_t      quat_z,
	input  qrm_pkg::comp_t      quat_w,
	output logic                done,
	output qrm_pkg::entry_t     m_r0c0,
	output qrm_pkg::entry_t     m_r1c0,
	output qrm_pkg::entry_t     m_r2c0,
	output qrm_pkg::entry_t     m_r0c1,
	output qrm_pkg::entry_t     m_r1c1,
	output qrm_pkg::entry_t     m_r2c1,
	output qrm_pkg::entry_t     m_r0c2,
	output qrm_pkg::entry_t     m_r1c2,
	output qrm_pkg::entry_t     m_r2c2,
	output logic                degenerate
);
	import qrm_pkg::*;

	assign busy = 1'b0;

	// stage 1: input capture
	logic  v_s1;
	comp_t x_s1, y_s1, z_s1, w_s1;

	// stage 2: products
	logic                    v_s2;
	logic signed [ProdW-1:0] xx_s2, yy_s2, zz_s2, ww_s2;
	logic signed [ProdW-1:0] xy_s2, xz_s2, yz_s2, wx_s2, wy_s2, wz_s2;

	// stage 3: norm and numerators
	logic                   v_s3;
	logic [NormW-1:0]       n_s3;
	logic signed [NumW-1:0] num_s3 [Lanes];

	// divider stages
	logic             v_d   [QBits+1];
	logic             dg_d  [QBits+1];
	logic [DenW-1:0]  den_d [QBits+1];
	logic [RemW-1:0]  rem_d [QBits+1][Lanes];
	logic [QBits-1:0] q_d   [QBits+1][Lanes];
	logic             neg_d [QBits+1][Lanes];

	entry_t ent_q [Lanes];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= quat_x;
		y_s1 <= quat_y;
		z_s1 <= quat_z;
		w_s1 <= quat_w;
		xx_s2 <= x_s1 * x_s1;
		yy_s2 <= y_s1 * y_s1;
		zz_s2 <= z_s1 * z_s1;
		ww_s2 <= w_s1 * w_s1;
		xy_s2 <= x_s1 * y_s1;
		xz_s2 <= x_s1 * z_s1;
		yz_s2 <= y_s1 * z_s1;
		wx_s2 <= w_s1 * x_s1;
		wy_s2 <= w_s1 * y_s1;
		wz_s2 <= w_s1 * z_s1;
	end

	logic [NormW-1:0]       n_c;
	logic signed [NumW-1:0] nn_c;
	always_comb begin
		n_c = NormW'(xx_s2) + NormW'(yy_s2) + NormW'(zz_s2) + NormW'(ww_s2);
		nn_c = NumW'(n_c);
	end

	always_ff @(posedge clk) begin
		n_s3 <= n_c;
		num_s3[0] <= nn_c - 2 * (NumW'(yy_s2) + NumW'(zz_s2));
		num_s3[1] <= 2 * (NumW'(xy_s2) + NumW'(wz_s2));
		num_s3[2] <= 2 * (NumW'(xz_s2) - NumW'(wy_s2));
		num_s3[3] <= 2 * (NumW'(xy_s2) - NumW'(wz_s2));
		num_s3[4] <= nn_c - 2 * (NumW'(xx_s2) + NumW'(zz_s2));
		num_s3[5] <= 2 * (NumW'(yz_s2) + NumW'(wx_s2));
		num_s3[6] <= 2 * (NumW'(xz_s2) + NumW'(wy_s2));
		num_s3[7] <= 2 * (NumW'(yz_s2) - NumW'(wx_s2));
		num_s3[8] <= nn_c - 2 * (NumW'(xx_s2) + NumW'(yy_s2));
	end

	// operand prep: magnitude scaled by 2^15 plus n for rounding, divisor 2n
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_d[0] <= 1'b0;
		else
			v_d[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		dg_d[0]  <= (n_s3 == '0);
		den_d[0] <= {n_s3, 1'b0};
	end

	for (genvar l = 0; l < Lanes; l++) begin : g_prep
		logic [MagW-1:0] mag;
		assign mag = num_s3[l][NumW-1] ? MagW'(-num_s3[l]) : MagW'(num_s3[l]);
		always_ff @(posedge clk) begin
			neg_d[0][l] <= num_s3[l][NumW-1];
			rem_d[0][l] <= {1'b0, mag, {QBits{1'b0}}} + RemW'(n_s3);
			q_d[0][l]   <= '0;
		end
	end

	// restoring divide, one quotient bit per stage, msb first
	for (genvar k = 0; k < QBits; k++) begin : g_div
		localparam int Sh = QBits - 1 - k;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_d[k+1] <= 1'b0;
			else
				v_d[k+1] <= v_d[k];
		end
		always_ff @(posedge clk) begin
			dg_d[k+1]  <= dg_d[k];
			den_d[k+1] <= den_d[k];
		end
		for (genvar l = 0; l < Lanes; l++) begin : g_lane
			logic [RemW-1:0] sub;
			logic            ge;
			assign sub = RemW'(den_d[k]) << Sh;
			assign ge  = rem_d[k][l] >= sub;
			always_ff @(posedge clk) begin
				neg_d[k+1][l] <= neg_d[k][l];
				rem_d[k+1][l] <= ge ? rem_d[k][l] - sub : rem_d[k][l];
				q_d[k+1][l]   <= q_d[k][l] | (ge ? QBits'(1) << Sh : '0);
			end
		end
	end

	// output register: sign, guard saturation, zero quaternion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= v_d[QBits];
	end

	always_ff @(posedge clk)
		degenerate <= dg_d[QBits];

	for (genvar l = 0; l < Lanes; l++) begin : g_out
		logic signed [QOutW-1:0] qv;
		assign qv = neg_d[QBits][l] ? -QOutW'(q_d[QBits][l]) : QOutW'(q_d[QBits][l]);
		always_ff @(posedge clk)
			ent_q[l] <= dg_d[QBits] ? '0 : sat_entry(qv);
	end

	assign m_r0c0 = ent_q[0];
	assign m_r1c0 = ent_q[1];
	assign m_r2c0 = ent_q[2];
	assign m_r0c1 = ent_q[3];
	assign m_r1c1 = ent_q[4];
	assign m_r2c1 = ent_q[5];
	assign m_r0c2 = ent_q[6];
	assign m_r1c2 = ent_q[7];
	assign m_r2c2 = ent_q[8];

	// zero quaternion gives an all-zero matrix (checked here on six of the nine entries)
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> m_r0c0 == '0 && m_r1c1 == '0 && m_r2c2 == '0
			&& m_r1c0 == '0 && m_r0c1 == '0 && m_r2c1 == '0)
		else $error("degenerate item with nonzero entries");

	// diagonal entries of a rotation stay within unit magnitude
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> m_r0c0 <= 16'sd16384 && m_r0c0 >= -16'sd16384
			&& m_r1c1 <= 16'sd16384 && m_r1c1 >= -16'sd16384
			&& m_r2c2 <= 16'sd16384 && m_r2c2 >= -16'sd16384)
		else $error("matrix entry out of unit range");

	// divider remainder of lane 0 stays below the divisor at the last stage
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_d[QBits] && !dg_d[QBits] |-> rem_d[QBits][0] < RemW'(den_d[QBits]))
		else $error("divider remainder not reduced");

endmodule
`default_nettype wire
